FILE: hdl/ppm_p6_header_parser_defines.svh
// Assertion macros for the P6 header parser.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef PPM_P6_HEADER_PARSER_DEFINES_SVH
`define PPM_P6_HEADER_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
// Check a consequence in the same cycle as its cause
`define PPM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppm_p6 same-cycle check failed");
// Check a consequence in the cycle after its cause
`define PPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppm_p6 next-cycle check failed");
`else
`define PPM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PPM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/ppm_p6_pkg.sv
// Shared types and constants of the P6 header parser.
// No dependencies; imported by every module of the block.
package ppm_p6_pkg;

    // Default sizes
    localparam int DIM_BITS_DEF     = 16;
    localparam int DIM_CHARS_DEF    = 10;
    localparam int MAXVAL_CHARS_DEF = 4;
    localparam int QUEUE_DEPTH      = 2;
    localparam int MAXVAL_LIMIT     = 255;

    // Character codes
    localparam logic [7:0] CH_P   = 8'h50;
    localparam logic [7:0] CH_6   = 8'h36;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;

    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_MAGIC        = 3'd0,
        ERR_WIDTH_LONG   = 3'd1,
        ERR_HEIGHT_LONG  = 3'd2,
        ERR_MAXVAL_LONG  = 3'd3,
        ERR_MAXVAL_RANGE = 3'd4,
        ERR_DIM_RANGE    = 3'd5
    } t_err;

    typedef enum logic [3:0] {
        PH_MAG0   = 4'd0,
        PH_MAG1   = 4'd1,
        PH_SKIP   = 4'd2,
        PH_WS_W   = 4'd3,
        PH_TOK_W  = 4'd4,
        PH_WS_H   = 4'd5,
        PH_TOK_H  = 4'd6,
        PH_WS_M   = 4'd7,
        PH_TOK_M  = 4'd8,
        PH_WS_PIX = 4'd9,
        PH_PIX    = 4'd10,
        PH_DONE   = 4'd11,
        PH_ERR    = 4'd12
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  pixel_byte;
        logic        last_pixel;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [7:0]  max_value;
        logic [2:0]  error_code;
    } t_out_item;

    // Classified byte as it travels from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       restart;
        logic       blank;
        logic       digit;
        logic [3:0] digit_val;
    } t_cls;

endpackage

FILE: hdl/ppm_p6_front.sv
// Front end of the P6 header parser: accepts raw bytes and classifies them.
// Depends on ppm_p6_pkg; feeds ppm_p6_queue.
module ppm_p6_front (
    input  logic                  i_in_valid,
    input  ppm_p6_pkg::t_in_item  i_in_item,
    input  logic                  i_q_full,
    output logic                  o_in_ready,
    output logic                  o_push,
    output ppm_p6_pkg::t_cls      o_cls
);
    import ppm_p6_pkg::*;

    logic [7:0] w_b;

    // Accept while the queue has room
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;
    assign w_b        = i_in_item.in_byte;

    // Classify the byte: whitespace, decimal digit and its value
    always_comb begin
        o_cls.data      = w_b;
        o_cls.restart   = i_in_item.first_byte;
        o_cls.blank     = (w_b == CH_SP) || (w_b == CH_LF) || (w_b == CH_CR)
                          || (w_b == CH_TAB);
        o_cls.digit     = (w_b >= CH_0) && (w_b <= CH_9);
        o_cls.digit_val = w_b[3:0];
    end

endmodule

FILE: hdl/ppm_p6_queue.sv
// Short queue of classified bytes between front and back.
// Depends on ppm_p6_pkg.
module ppm_p6_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ppm_p6_pkg::t_cls  i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output ppm_p6_pkg::t_cls  o_data
);
    import ppm_p6_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cls             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    // Advance pointers with wrap, track fill
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: hdl/ppm_p6_back.sv
// Back end of the P6 header parser: header state machine, pixel counter and
// output register. Depends on ppm_p6_pkg; fed by ppm_p6_queue.
module ppm_p6_back #(
    parameter int DIM_BITS     = ppm_p6_pkg::DIM_BITS_DEF,
    parameter int DIM_CHARS    = ppm_p6_pkg::DIM_CHARS_DEF,
    parameter int MAXVAL_CHARS = ppm_p6_pkg::MAXVAL_CHARS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  ppm_p6_pkg::t_cls      i_cls,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ppm_p6_pkg::t_out_item o_out_item
);
    import ppm_p6_pkg::*;

    localparam int VAL_W   = DIM_BITS + 1;
    localparam int EXT_W   = VAL_W + 4;
    localparam int LEN_W   = $clog2(DIM_CHARS + 1);
    localparam int AREA_W  = 2 * DIM_BITS;
    localparam int COUNT_W = AREA_W + 2;

    t_phase              r_phase, n_phase;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [VAL_W-1:0]    r_val, n_val;
    logic                r_stop, n_stop;
    logic [DIM_BITS-1:0] r_width, n_width;
    logic [DIM_BITS-1:0] r_height, n_height;
    logic [AREA_W-1:0]   r_area;
    logic [COUNT_W-1:0]  r_left, n_left;
    logic                r_out_valid;
    t_out_item           r_out;

    t_phase              w_cur;
    t_phase              w_tok;
    logic                w_start;
    logic [LEN_W-1:0]    w_len;
    logic [VAL_W-1:0]    w_val;
    logic                w_stop;
    logic [EXT_W-1:0]    w_acc;
    logic [LEN_W-1:0]    w_lim;
    t_err                w_long_code;
    logic                w_fail;
    t_err                w_fail_code;
    logic                w_has_res;
    t_out_item           w_res;
    logic [DIM_BITS+15:0] w_wext;
    logic [DIM_BITS+15:0] w_hext;

    assign o_pop       = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign w_wext      = {16'b0, r_width};
    assign w_hext      = {16'b0, r_height};

    // Token bookkeeping shared by the three token phases
    always_comb begin
        w_cur   = i_cls.restart ? PH_MAG0 : r_phase;
        w_start = ((w_cur == PH_WS_W) || (w_cur == PH_WS_H) || (w_cur == PH_WS_M))
                  && !i_cls.blank;
        w_len   = w_start ? '0 : r_len;
        w_val   = w_start ? '0 : r_val;
        w_stop  = w_start ? 1'b0 : r_stop;
        unique case (w_cur)
            PH_WS_W, PH_TOK_W: w_tok = PH_TOK_W;
            PH_WS_H, PH_TOK_H: w_tok = PH_TOK_H;
            default:           w_tok = PH_TOK_M;
        endcase
        if (w_tok == PH_TOK_M) begin
            w_lim       = LEN_W'(MAXVAL_CHARS);
            w_long_code = ERR_MAXVAL_LONG;
        end else if (w_tok == PH_TOK_H) begin
            w_lim       = LEN_W'(DIM_CHARS);
            w_long_code = ERR_HEIGHT_LONG;
        end else begin
            w_lim       = LEN_W'(DIM_CHARS);
            w_long_code = ERR_WIDTH_LONG;
        end
        // value*10 + digit, saturated at 2^DIM_BITS
        w_acc = ({4'b0, w_val} << 3) + ({4'b0, w_val} << 1)
                + EXT_W'(i_cls.digit_val);
        if (w_acc > (EXT_W'(1) << DIM_BITS)) begin
            w_acc = EXT_W'(1) << DIM_BITS;
        end
    end

    // Next state and result of one classified byte
    always_comb begin
        n_phase     = w_cur;
        n_len       = r_len;
        n_val       = r_val;
        n_stop      = r_stop;
        n_width     = r_width;
        n_height    = r_height;
        n_left      = r_left;
        w_fail      = 1'b0;
        w_fail_code = ERR_MAGIC;
        w_has_res   = 1'b0;
        w_res       = '0;
        unique case (w_cur)
            PH_MAG0: begin
                if (i_cls.data != CH_P) begin
                    w_fail = 1'b1;
                end else begin
                    n_phase = PH_MAG1;
                end
            end
            PH_MAG1: begin
                if (i_cls.data != CH_6) begin
                    w_fail = 1'b1;
                end else begin
                    n_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                n_phase = PH_WS_W;
            end
            PH_WS_W, PH_TOK_W, PH_WS_H, PH_TOK_H, PH_WS_M, PH_TOK_M: begin
                if (!i_cls.blank) begin
                    // add one token character
                    if (w_len >= w_lim) begin
                        w_fail      = 1'b1;
                        w_fail_code = w_long_code;
                    end else begin
                        n_phase = w_tok;
                        n_len   = w_len + 1'b1;
                        n_val   = w_val;
                        n_stop  = w_stop;
                        if (!w_stop && i_cls.digit) begin
                            n_val = w_acc[VAL_W-1:0];
                        end else begin
                            n_stop = 1'b1;
                        end
                    end
                end else if (w_cur == PH_TOK_W || w_cur == PH_TOK_H) begin
                    // close a dimension token
                    if (r_val[DIM_BITS]) begin
                        w_fail      = 1'b1;
                        w_fail_code = ERR_DIM_RANGE;
                    end else if (w_cur == PH_TOK_W) begin
                        n_width = r_val[DIM_BITS-1:0];
                        n_phase = PH_WS_H;
                    end else begin
                        n_height = r_val[DIM_BITS-1:0];
                        n_phase  = PH_WS_M;
                    end
                end else if (w_cur == PH_TOK_M) begin
                    // close maxval and report the header
                    if (r_val > VAL_W'(MAXVAL_LIMIT)) begin
                        w_fail      = 1'b1;
                        w_fail_code = ERR_MAXVAL_RANGE;
                    end else begin
                        n_left  = ({2'b0, r_area} << 1) + {2'b0, r_area};
                        n_phase = (r_area != '0) ? PH_WS_PIX : PH_DONE;
                        w_has_res          = 1'b1;
                        w_res.kind         = KIND_HEADER;
                        w_res.image_width  = w_wext[15:0];
                        w_res.image_height = w_hext[15:0];
                        w_res.max_value    = r_val[7:0];
                    end
                end
            end
            PH_WS_PIX, PH_PIX: begin
                if (w_cur == PH_PIX && r_left == '0) begin
                    n_phase = PH_DONE;
                end else if (w_cur == PH_PIX || !i_cls.blank) begin
                    // pass one pixel byte, mark the final one
                    n_left             = r_left - 1'b1;
                    n_phase            = (r_left == COUNT_W'(1)) ? PH_DONE : PH_PIX;
                    w_has_res          = 1'b1;
                    w_res.kind         = KIND_PIXEL;
                    w_res.pixel_byte   = i_cls.data;
                    w_res.last_pixel   = (r_left == COUNT_W'(1));
                end
            end
            default: begin
                n_phase = w_cur;
            end
        endcase
        if (w_fail) begin
            n_phase          = PH_ERR;
            w_has_res        = 1'b1;
            w_res            = '0;
            w_res.kind       = KIND_ERROR;
            w_res.error_code = w_fail_code;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_MAG0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
            end
            if (o_pop && w_has_res) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers; area is recomputed each cycle from the dimensions
    always_ff @(posedge i_clk) begin
        r_area <= r_width * r_height;
        if (o_pop) begin
            r_len    <= n_len;
            r_val    <= n_val;
            r_stop   <= n_stop;
            r_width  <= n_width;
            r_height <= n_height;
            r_left   <= n_left;
        end
        if (o_pop && w_has_res) begin
            r_out <= w_res;
        end
    end

endmodule

FILE: hdl/ppm_p6_header_parser.sv
// Top level of the P6 header parser: front classifier, byte queue, back end.
// Depends on ppm_p6_pkg, ppm_p6_front, ppm_p6_queue, ppm_p6_back and the defines header.
//
//  channel | valid        | ready        | payload
//  --------+--------------+--------------+--------------------------
//  input   | i_in_valid   | o_in_ready   | i_in_item  (t_in_item)
//  output  | o_out_valid  | i_out_ready  | o_out_item (t_out_item)
//
// One byte per cycle sustained while the output is taken. A byte is written to
// the queue when accepted and then stepped through the parser into the output
// register. The pixel byte count is loaded from three times width*height,
// whose product the back end keeps in a register of its own.
// Synchronous active-low reset clears control state only; no clearing pass.
// While a result waits on the output the parser holds; the two-entry queue
// takes up to two more bytes before o_in_ready drops.
`include "ppm_p6_header_parser_defines.svh"
module ppm_p6_header_parser #(
    parameter int DIM_BITS     = ppm_p6_pkg::DIM_BITS_DEF,
    parameter int DIM_CHARS    = ppm_p6_pkg::DIM_CHARS_DEF,
    parameter int MAXVAL_CHARS = ppm_p6_pkg::MAXVAL_CHARS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ppm_p6_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ppm_p6_pkg::t_out_item o_out_item
);
    import ppm_p6_pkg::*;

    logic w_push;
    logic w_full;
    logic w_q_valid;
    logic w_pop;
    t_cls w_cls_in;
    t_cls w_cls_out;

    // Classify incoming bytes
    ppm_p6_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_q_full   (w_full),
        .o_in_ready (o_in_ready),
        .o_push     (w_push),
        .o_cls      (w_cls_in)
    );

    // Decouple front and back
    ppm_p6_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cls_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_cls_out)
    );

    // Parse header, count pixels, hold results
    ppm_p6_back #(
        .DIM_BITS     (DIM_BITS),
        .DIM_CHARS    (DIM_CHARS),
        .MAXVAL_CHARS (MAXVAL_CHARS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_cls       (w_cls_out),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // A stalled result blocks the parser
    `PPM_ASSERT_NOW(a_no_pop_on_stall, i_clk, i_rst_n, o_out_valid && !i_out_ready, !w_pop)
    // A taken byte is waiting in the queue on the next cycle
    `PPM_ASSERT_NEXT(a_taken_queued, i_clk, i_rst_n, i_in_valid && o_in_ready, w_q_valid)
    // Only pixel results carry the final-pixel mark
    `PPM_ASSERT_NOW(a_last_is_pixel, i_clk, i_rst_n, o_out_valid && o_out_item.last_pixel, o_out_item.kind == KIND_PIXEL)

endmodule

FILE: test/ppm_p6_header_parser_test.sv
// Self-checking testbench for the P6 header parser: streams PPM files byte by byte,
// predicts every header, pixel and error item, and checks them as they come out.
// Depends on ppm_p6_pkg and the ppm_p6_header_parser top level.
`timescale 1ns / 100ps

module ppm_p6_header_parser_test;
    import ppm_p6_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;
    localparam int PHASE_BYTES = 345;

    // Tracks parser state, predicts results and checks the output stream
    class parse_checker;
        t_phase    ph;
        int        tok_len;
        longint    tok_val;
        bit        stopped;
        longint    wid;
        longint    hgt;
        longint    left;
        int        mval;
        int        failures;
        int        bytes_used;
        t_out_item awaited[$];

        function new();
            clear_state();
            failures = 0;
            bytes_used = 0;
        endfunction

        function void clear_state();
            ph = PH_MAG0;
            tok_len = 0;
            tok_val = 0;
            stopped = 0;
            wid = 0;
            hgt = 0;
            left = 0;
            mval = 0;
        endfunction

        function bit is_blank(logic [7:0] b);
            return b == CH_SP || b == CH_LF || b == CH_CR || b == CH_TAB;
        endfunction

        // Advance the parser by one accepted byte and queue what it yields
        function void take_byte(t_in_item item);
            t_out_item r;
            logic [7:0] b;
            bit ws;
            bit bad;
            bit has;
            t_err code;
            int lim;
            longint dim_max;
            longint cap;

            b = item.in_byte;
            ws = is_blank(b);
            bad = 0;
            has = 0;
            code = ERR_MAGIC;
            r = '0;
            cap = 64'd1 << DIM_BITS_DEF;
            dim_max = cap - 1;

            if (item.first_byte)
                clear_state();
            bytes_used++;

            // A non-blank byte in a separator phase opens the next token
            if (ph inside {PH_WS_W, PH_WS_H, PH_WS_M} && !ws) begin
                tok_len = 0;
                tok_val = 0;
                stopped = 0;
                ph = t_phase'(ph + 1);
            end

            case (ph)
                PH_MAG0: begin
                    if (b != CH_P) begin
                        bad = 1;
                    end else begin
                        ph = PH_MAG1;
                    end
                end
                PH_MAG1: begin
                    if (b != CH_6) begin
                        bad = 1;
                    end else begin
                        ph = PH_SKIP;
                    end
                end
                PH_SKIP: ph = PH_WS_W;
                PH_TOK_W, PH_TOK_H, PH_TOK_M: begin
                    if (!ws) begin
                        lim = (ph == PH_TOK_M) ? MAXVAL_CHARS_DEF : DIM_CHARS_DEF;
                        if (tok_len >= lim) begin
                            bad = 1;
                            code = (ph == PH_TOK_W) ? ERR_WIDTH_LONG :
                                   (ph == PH_TOK_H) ? ERR_HEIGHT_LONG : ERR_MAXVAL_LONG;
                        end else begin
                            tok_len++;
                            if (!stopped && b >= CH_0 && b <= CH_9) begin
                                tok_val = tok_val * 10 + longint'(b - CH_0);
                                if (tok_val > cap)
                                    tok_val = cap;
                            end else begin
                                stopped = 1;
                            end
                        end
                    end else if (ph == PH_TOK_W) begin
                        if (tok_val > dim_max) begin
                            bad = 1;
                            code = ERR_DIM_RANGE;
                        end else begin
                            wid = tok_val;
                            ph = PH_WS_H;
                        end
                    end else if (ph == PH_TOK_H) begin
                        if (tok_val > dim_max) begin
                            bad = 1;
                            code = ERR_DIM_RANGE;
                        end else begin
                            hgt = tok_val;
                            ph = PH_WS_M;
                        end
                    end else begin
                        if (tok_val > MAXVAL_LIMIT) begin
                            bad = 1;
                            code = ERR_MAXVAL_RANGE;
                        end else begin
                            mval = int'(tok_val);
                            left = wid * hgt * 3;
                            ph = (left != 0) ? PH_WS_PIX : PH_DONE;
                            r.kind = KIND_HEADER;
                            r.image_width = 16'(wid);
                            r.image_height = 16'(hgt);
                            r.max_value = 8'(mval);
                            has = 1;
                        end
                    end
                end
                PH_WS_PIX, PH_PIX: begin
                    if (ph == PH_PIX && left == 0) begin
                        ph = PH_DONE;
                    end else if (!(ph == PH_WS_PIX && ws)) begin
                        left--;
                        ph = (left == 0) ? PH_DONE : PH_PIX;
                        r.kind = KIND_PIXEL;
                        r.pixel_byte = b;
                        r.last_pixel = (left == 0);
                        has = 1;
                    end
                end
                default: ;
            endcase

            if (bad) begin
                ph = PH_ERR;
                r = '0;
                r.kind = KIND_ERROR;
                r.error_code = code;
                has = 1;
            end
            if (has)
                awaited.push_back(r);
        endfunction

        function void compare(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                failures++;
            end
        endfunction

        // Match one output item against the oldest prediction
        function void check_result(t_out_item got);
            t_out_item want;
            if (awaited.size() == 0) begin
                $error("unexpected item: kind %0d", got.kind);
                failures++;
                return;
            end
            want = awaited.pop_front();
            compare("kind", want.kind, got.kind);
            compare("pixel_byte", want.pixel_byte, got.pixel_byte);
            compare("last_pixel", want.last_pixel, got.last_pixel);
            compare("image_width", want.image_width, got.image_width);
            compare("image_height", want.image_height, got.image_height);
            compare("max_value", want.max_value, got.max_value);
            compare("error_code", want.error_code, got.error_code);
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    int send_idle = 0;
    int recv_idle = 0;
    int quiet = 0;
    logic [7:0] file_q[$];
    parse_checker board = new();

    ppm_p6_header_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    always #5 i_clk = ~i_clk;

    // Stall the output at random
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Observe both handshakes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && in_ready)
                board.take_byte(in_item);
            if (out_valid && out_ready)
                board.check_result(out_item);
        end
    end

    // End the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Offer one byte and hold it until taken
    task automatic send_byte(logic [7:0] b, logic first);
        t_in_item item;
        item.in_byte = b;
        item.first_byte = first;
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= item;
        @(posedge i_clk);
        while (!in_ready)
            @(posedge i_clk);
    endtask

    task automatic send_file(bit restart);
        for (int i = 0; i < file_q.size(); i++)
            send_byte(file_q[i], restart && i == 0);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            file_q.push_back(s[i]);
    endtask

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 3))
            0: return CH_SP;
            1: return CH_LF;
            2: return CH_CR;
            default: return CH_TAB;
        endcase
    endfunction

    // Any byte that neither separates nor counts as a digit
    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while ((c >= CH_0 && c <= CH_9) || c == CH_SP || c == CH_LF || c == CH_CR ||
               c == CH_TAB);
        return c;
    endfunction

    task automatic add_blanks(int lo, int hi);
        repeat ($urandom_range(lo, hi))
            file_q.push_back(blank_char());
    endtask

    function automatic string padded(longint v, int n);
        string s;
        s = $sformatf("%0d", v);
        while (s.len() < n)
            s = {"0", s};
        return s;
    endfunction

    // Width or height token; big values only where the pixel count stays small
    task automatic add_dim_token(bit allow_big, output longint val);
        longint v;
        v = $urandom_range(0, 4);
        val = v;
        case ($urandom_range(0, 19))
            14: begin
                if (allow_big) begin
                    case ($urandom_range(0, 4))
                        0: v = 65535;
                        1: v = 65536;
                        2: v = $urandom_range(5, 65535);
                        3: v = 99999999;
                        default: v = 64'd9999999999;
                    endcase
                end
                val = v;
                add_text(padded(v, 0));
            end
            15: add_text(padded(v, DIM_CHARS_DEF + 1));
            16: begin
                add_text(padded(v, 0));
                file_q.push_back(junk_char());
                if ($urandom_range(0, 1))
                    add_text("7");
            end
            17: begin
                val = 0;
                file_q.push_back(junk_char());
                add_text(padded(v, 0));
            end
            18: add_text(padded(v, DIM_CHARS_DEF));
            default: add_text(padded(v, $urandom_range(1, 3)));
        endcase
    endtask

    task automatic add_maxval_token();
        int v;
        case ($urandom_range(0, 9))
            6: add_text($urandom_range(0, 1) ? "255" : padded(0, $urandom_range(1, 4)));
            7: add_text(padded($urandom_range(256, 9999), 0));
            8: add_text(padded($urandom_range(0, 255), MAXVAL_CHARS_DEF + 1));
            9: begin
                add_text(padded($urandom_range(0, 99), 0));
                file_q.push_back(junk_char());
            end
            default: begin
                v = $urandom_range(0, 255);
                add_text(padded(v, $urandom_range(1, MAXVAL_CHARS_DEF)));
            end
        endcase
    endtask

    // Build one file, mostly well formed, sometimes damaged
    task automatic build_file();
        longint w;
        longint h;
        longint npix;
        file_q.delete();
        if ($urandom_range(0, 15) == 0) begin
            repeat ($urandom_range(1, 6))
                file_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        file_q.push_back(CH_P);
        file_q.push_back(CH_6);
        file_q.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : CH_LF);
        add_blanks(0, 2);
        add_dim_token(1'b1, w);
        add_blanks(1, 3);
        if (w > 4) begin
            add_text("0");
            h = 0;
        end else begin
            add_dim_token(w == 0, h);
        end
        add_blanks(1, 3);
        add_maxval_token();
        add_blanks(1, 3);
        npix = (w <= 4 && h <= 4) ? w * h * 3 : 0;
        repeat (npix)
            file_q.push_back(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 2))
            file_q.push_back(8'($urandom_range(0, 255)));
        // Damage the magic or cut the file short now and then
        if ($urandom_range(0, 19) == 0)
            file_q[$urandom_range(0, 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0)
            file_q = file_q[0:$urandom_range(0, file_q.size() - 2)];
    endtask

    task automatic run_phase(int s_idle, int r_idle);
        int goal;
        goal = board.bytes_used + PHASE_BYTES;
        send_idle = s_idle;
        recv_idle = r_idle;
        while (board.bytes_used < goal) begin
            build_file();
            send_file($urandom_range(0, 19) != 0);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle = 31;
        recv_idle = 82;

        // Small image with a blank byte inside the pixel data, then a trailing byte
        file_q.delete();
        add_text("P6");
        file_q.push_back(CH_LF);
        add_text("2 1");
        file_q.push_back(CH_LF);
        add_text("255");
        file_q.push_back(CH_LF);
        file_q.push_back(8'h00);
        file_q.push_back(CH_SP);
        file_q.push_back(8'hFF);
        file_q.push_back(8'h80);
        file_q.push_back(8'h7F);
        file_q.push_back(8'h01);
        file_q.push_back(8'hAA);
        send_file(1'b1);

        // Bad first magic byte, then a byte that must be ignored
        send_byte("Q", 1'b1);
        send_byte("X", 1'b0);
        // Bad second magic byte
        send_byte(CH_P, 1'b1);
        send_byte("5", 1'b1 == 1'b0);

        run_phase(31, 82);
        run_phase(82, 31);
        run_phase(0, 0);
        in_valid <= 1'b0;

        // Drain, then give the block time to show any stray item
        while (board.awaited.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
